// File: rtl/direct_mapped_cache_lookup_defines.svh
// ============================================================================
// Direct-mapped cache lookup: assertion macros
// Shared property forms for the checker, clocked and held off during reset.
// ============================================================================
`ifndef DIRECT_MAPPED_CACHE_LOOKUP_DEFINES_SVH
`define DIRECT_MAPPED_CACHE_LOOKUP_DEFINES_SVH

// Same-cycle implication.
`define DMC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DMC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dmc_pkg.sv
// ============================================================================
// dmc_pkg
// Constants and types shared by the cache lookup modules, and the line map.
// ============================================================================
`timescale 1ns / 1ps

package dmc_pkg;

    localparam int NUM_LINES   = 256;
    localparam int BLOCK_BYTES = 256;

    localparam int ADDR_W   = 64;
    localparam int DATA_W   = 64;
    localparam int TAG_W    = 48;
    localparam int INDEX_W  = 8;
    localparam int OFFSET_W = 8;
    localparam int VALUE_W  = 32;

    localparam int BEAT_BYTES  = DATA_W / 8;
    localparam int BEAT_SHIFT  = $clog2(BEAT_BYTES);
    localparam int VALUE_BYTES = VALUE_W / 8;
    localparam int WSEL_W      = OFFSET_W - BEAT_SHIFT;

    localparam int WORDS_PER_LINE = (BLOCK_BYTES + BEAT_BYTES - 1) / BEAT_BYTES;
    localparam int MEM_DEPTH      = NUM_LINES * WORDS_PER_LINE;
    localparam int MEM_AW         = $clog2(MEM_DEPTH);
    localparam int LINE_W         = $clog2(NUM_LINES);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int INDEX_COUNT = 2 ** INDEX_W;

    typedef logic [LINE_W-1:0] line_t;
    typedef logic [MEM_AW-1:0] maddr_t;
    typedef line_t line_map_t [INDEX_COUNT];

    // Address index to physical line (index mod NUM_LINES), built at elaboration.
    function automatic line_map_t build_line_map();
        line_map_t m;
        for (int i = 0; i < INDEX_COUNT; i++)
        begin
            m[i] = line_t'(i % NUM_LINES);
        end
        return m;
    endfunction

    localparam line_map_t LINE_MAP = build_line_map();

    // One classified request waiting between front and back.
    typedef struct packed {
        logic                   is_fill;
        logic                   fill_last;
        logic [TAG_W-1:0]       tag;
        logic [INDEX_W-1:0]     index;
        logic [OFFSET_W-1:0]    offset;
        line_t                  line;
        maddr_t                 addr_lo;
        maddr_t                 addr_hi;
        logic [BEAT_BYTES-1:0]  byte_en;
        logic [VALUE_BYTES-1:0] rd_mask;
        logic [DATA_W-1:0]      fill_data;
    } dmc_entry_t;

endpackage

// File: rtl/dmc_if.sv
// ============================================================================
// dmc_req_if / dmc_rsp_if
// Valid/ready channels for cache requests and results.
// ============================================================================
`timescale 1ns / 1ps

interface dmc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [dmc_pkg::ADDR_W-1:0]    address;
    logic [dmc_pkg::DATA_W-1:0]    fill_data;
    logic                          fill_last;

    modport source (output valid, kind, address, fill_data, fill_last, input ready);
    modport sink   (input valid, kind, address, fill_data, fill_last, output ready);
endinterface

interface dmc_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               hit;
    logic signed [dmc_pkg::VALUE_W-1:0] read_value;
    logic [dmc_pkg::TAG_W-1:0]          tag_field;
    logic [dmc_pkg::INDEX_W-1:0]        line_index;
    logic [dmc_pkg::OFFSET_W-1:0]       byte_offset;

    modport source (output valid, hit, read_value, tag_field, line_index, byte_offset,
                    input ready);
    modport sink   (input valid, hit, read_value, tag_field, line_index, byte_offset,
                    output ready);
endinterface

// File: rtl/dmc_front.sv
// ============================================================================
// dmc_front
// Accept requests, split the address and work out line, memory addresses
// and byte masks for the back end.
// ============================================================================
`timescale 1ns / 1ps

module dmc_front (
    dmc_req_if.sink              req,
    input  logic                 full,
    output logic                 push,
    output dmc_pkg::dmc_entry_t  push_entry
);
    import dmc_pkg::*;

    logic [WSEL_W-1:0] wsel;
    logic              w0_in;
    logic              w1_in;
    line_t             line;
    maddr_t            line_base;

    assign req.ready = !full;
    assign push      = req.valid && !full;

    always_comb
    begin
        push_entry           = '0;
        push_entry.is_fill   = req.kind;
        push_entry.fill_last = req.fill_last;
        push_entry.fill_data = req.fill_data;
        push_entry.offset    = req.address[OFFSET_W-1:0];
        push_entry.index     = req.address[OFFSET_W +: INDEX_W];
        push_entry.tag       = req.address[OFFSET_W+INDEX_W +: TAG_W];

        line      = LINE_MAP[push_entry.index];
        wsel      = push_entry.offset[OFFSET_W-1:BEAT_SHIFT];
        w0_in     = 32'(wsel) < 32'(WORDS_PER_LINE);
        w1_in     = (32'(wsel) + 32'd1) < 32'(WORDS_PER_LINE);
        line_base = maddr_t'(line) * maddr_t'(WORDS_PER_LINE);

        push_entry.line    = line;
        push_entry.addr_lo = w0_in ? line_base + maddr_t'(wsel) : line_base;
        push_entry.addr_hi = w1_in ? line_base + maddr_t'(wsel) + maddr_t'(1) : line_base;

        // Drop beat bytes and word bytes that fall past the end of the block.
        for (int i = 0; i < BEAT_BYTES; i++)
        begin
            push_entry.byte_en[i] = (32'(wsel) * 32'(BEAT_BYTES) + 32'(i))
                                    < 32'(BLOCK_BYTES);
        end
        for (int i = 0; i < VALUE_BYTES; i++)
        begin
            push_entry.rd_mask[i] = (32'(push_entry.offset) + 32'(i)) < 32'(BLOCK_BYTES);
        end
    end

endmodule

// File: rtl/dmc_queue.sv
// ============================================================================
// dmc_queue
// Small FIFO of classified requests between front and back.
// ============================================================================
`timescale 1ns / 1ps

module dmc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dmc_pkg::dmc_entry_t  push_entry,
    output logic                 full,
    input  logic                 pop,
    output dmc_pkg::dmc_entry_t  pop_entry,
    output logic                 empty
);
    import dmc_pkg::*;

    dmc_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full      = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty     = count_reg == '0;
    assign pop_entry = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/dmc_back.sv
// ============================================================================
// dmc_back
// Carry out requests against the tag and data memories and hold the result
// register.
// ============================================================================
`timescale 1ns / 1ps

module dmc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 empty,
    input  dmc_pkg::dmc_entry_t  entry,
    output logic                 pop,
    dmc_rsp_if.source            rsp
);
    import dmc_pkg::*;

    typedef enum logic {S_ISSUE, S_RESOLVE} state_t;

    state_t                    state_reg;
    dmc_entry_t                cur_reg;
    logic [NUM_LINES-1:0]      valid_reg;
    logic                      rsp_valid_reg;
    logic                      hit_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [TAG_W-1:0]          tag_out_reg;
    logic [INDEX_W-1:0]        index_out_reg;
    logic [OFFSET_W-1:0]       offset_out_reg;

    logic [TAG_W-1:0]          tag_mem [NUM_LINES];
    logic [DATA_W-1:0]         data_mem [MEM_DEPTH];
    logic [TAG_W-1:0]          rd_tag_reg;
    logic [DATA_W-1:0]         rd_lo_reg;
    logic [DATA_W-1:0]         rd_hi_reg;

    logic                      out_free;
    logic                      lookup_hit;
    logic [2*DATA_W-1:0]       window;
    logic [VALUE_W-1:0]        word;

    assign out_free = !rsp_valid_reg || rsp.ready;
    assign pop      = (state_reg == S_ISSUE) && !empty && out_free;

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.hit         = hit_reg;
    assign rsp.read_value  = value_reg;
    assign rsp.tag_field   = tag_out_reg;
    assign rsp.line_index  = index_out_reg;
    assign rsp.byte_offset = offset_out_reg;

    // Memories: byte-enabled fill write, registered reads at issue.
    always_ff @(posedge clk)
    begin
        if (pop && entry.is_fill)
        begin
            tag_mem[entry.line] <= entry.tag;
            for (int i = 0; i < BEAT_BYTES; i++)
            begin
                if (entry.byte_en[i])
                begin
                    data_mem[entry.addr_lo][8*i +: 8] <= entry.fill_data[8*i +: 8];
                end
            end
        end
        rd_tag_reg <= tag_mem[entry.line];
        rd_lo_reg  <= data_mem[entry.addr_lo];
        rd_hi_reg  <= data_mem[entry.addr_hi];
    end

    always_comb
    begin
        lookup_hit = valid_reg[cur_reg.line] && (rd_tag_reg == cur_reg.tag);
        window     = {rd_hi_reg, rd_lo_reg} >> {cur_reg.offset[BEAT_SHIFT-1:0], 3'b000};
        word       = window[VALUE_W-1:0];
        for (int i = 0; i < VALUE_BYTES; i++)
        begin
            if (!cur_reg.rd_mask[i] || !lookup_hit)
            begin
                word[8*i +: 8] = 8'h00;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_ISSUE;
            cur_reg        <= '0;
            valid_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            value_reg      <= '0;
            tag_out_reg    <= '0;
            index_out_reg  <= '0;
            offset_out_reg <= '0;
        end
        else
        begin
            if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_ISSUE:
                begin
                    if (pop)
                    begin
                        cur_reg <= entry;
                        if (entry.is_fill)
                        begin
                            // Beat stores the tag and clears valid; last beat sets it.
                            valid_reg[entry.line] <= entry.fill_last;
                            rsp_valid_reg  <= 1'b1;
                            hit_reg        <= 1'b0;
                            value_reg      <= '0;
                            tag_out_reg    <= entry.tag;
                            index_out_reg  <= entry.index;
                            offset_out_reg <= entry.offset;
                        end
                        else
                        begin
                            state_reg <= S_RESOLVE;
                        end
                    end
                end
                S_RESOLVE:
                begin
                    rsp_valid_reg  <= 1'b1;
                    hit_reg        <= lookup_hit;
                    value_reg      <= word;
                    tag_out_reg    <= cur_reg.tag;
                    index_out_reg  <= cur_reg.index;
                    offset_out_reg <= cur_reg.offset;
                    state_reg      <= S_ISSUE;
                end
                default:
                begin
                    state_reg <= S_ISSUE;
                end
            endcase
        end
    end

endmodule

// File: rtl/direct_mapped_cache_lookup.sv
// ============================================================================
// direct_mapped_cache_lookup
// Direct-mapped cache of NUM_LINES lines by BLOCK_BYTES bytes with lookup
// and fill-beat requests.
// ============================================================================
// Each request on req gives exactly one result on rsp, in request order.
// The front end takes a request whenever the two-entry queue has room and
// classifies it (tag, index, offset, line, memory addresses, byte masks).
// The back end drains the queue: a fill beat is handled in the issue state
// (tag and data write, valid bit update), its result registered along with
// the write; a lookup goes on from issue to resolve, because the tag and the
// two data words around the offset come out of registered memory reads
// before the tag compare and the word selection, and no new request is taken
// until it resolves. Sustained rate: one fill beat per cycle; fills and
// lookups are both held up while rsp is stalled.
// Valid bits are flip-flops cleared by reset, so the block takes requests
// right after reset with no clearing pass. Tag and data memories start
// undefined; a hit on bytes no fill has written returns unspecified data.
// ============================================================================
`timescale 1ns / 1ps

module direct_mapped_cache_lookup (
    input  logic       clk,
    input  logic       rst_n,
    dmc_req_if.sink    req,
    dmc_rsp_if.source  rsp
);
    import dmc_pkg::*;

    // Front to queue.
    logic       push;
    dmc_entry_t push_entry;
    logic       full;

    // Queue to back.
    logic       pop;
    dmc_entry_t pop_entry;
    logic       empty;

    // Classify the request; hold it off while the queue is full.
    dmc_front u_front (
        .req        (req),
        .full       (full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decouple the front from stalls in the back and on rsp.
    dmc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (empty)
    );

    // Advance one request at a time through the memories into the result register.
    dmc_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .empty (empty),
        .entry (pop_entry),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

// File: rtl/dmc_checker.sv
// ============================================================================
// dmc_checker
// Port-level checks on the cache lookup, attached to the top level by bind.
// ============================================================================
`timescale 1ns / 1ps
`include "direct_mapped_cache_lookup_defines.svh"

module dmc_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               req_valid,
    input logic                               req_ready,
    input logic                               rsp_valid,
    input logic                               rsp_ready,
    input logic                               rsp_hit,
    input logic signed [dmc_pkg::VALUE_W-1:0] rsp_read_value,
    input logic [dmc_pkg::TAG_W-1:0]          rsp_tag_field,
    input logic [dmc_pkg::INDEX_W-1:0]        rsp_line_index,
    input logic [dmc_pkg::OFFSET_W-1:0]       rsp_byte_offset
);
    import dmc_pkg::*;

    logic [3:0] pending_reg;
    logic       req_take;
    logic       rsp_take;

    assign req_take = req_valid && req_ready;
    assign rsp_take = rsp_valid && rsp_ready;

    // Requests taken but not yet answered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (req_take && !rsp_take)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (rsp_take && !req_take)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    `DMC_ASSERT_IMP(a_rsp_has_req, clk, rst_n, rsp_valid, pending_reg != '0,
        "result shown with no request outstanding")

    `DMC_ASSERT_IMP(a_miss_zero, clk, rst_n, rsp_valid && !rsp_hit, rsp_read_value == '0,
        "nonzero read value on a miss or fill result")

    `DMC_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid,
        "result dropped while stalled")

    `DMC_ASSERT_NXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready,
        $stable(rsp_hit) && $stable(rsp_read_value) && $stable(rsp_tag_field)
            && $stable(rsp_line_index) && $stable(rsp_byte_offset),
        "result changed while stalled")

endmodule

bind direct_mapped_cache_lookup dmc_checker u_dmc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_hit         (rsp.hit),
    .rsp_read_value  (rsp.read_value),
    .rsp_tag_field   (rsp.tag_field),
    .rsp_line_index  (rsp.line_index),
    .rsp_byte_offset (rsp.byte_offset)
);

// File: dv/dmc_tb_pkg.sv
// ============================================================================
// dmc_tb_pkg
// Request kind codes used by the cache lookup testbench and its checker.
// ============================================================================
`timescale 1ns / 1ps

package dmc_tb_pkg;

    typedef enum logic {
        KIND_LOOKUP = 1'b0,
        KIND_FILL   = 1'b1
    } req_kind_t;

endpackage

// File: dv/dmc_result_checker.sv
// ============================================================================
// dmc_result_checker
// Watches the request and result channels, keeps its own copy of the cache
// and compares every result with the oldest outstanding prediction.
// ============================================================================
`timescale 1ns / 1ps

module dmc_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    dmc_req_if          req,
    dmc_rsp_if          rsp,
    output int unsigned errors,
    output int unsigned pending
);

    import dmc_pkg::*;
    import dmc_tb_pkg::*;

    typedef struct packed {
        logic                      hit;
        logic signed [VALUE_W-1:0] value;
        logic [TAG_W-1:0]          tag;
        logic [INDEX_W-1:0]        index;
        logic [OFFSET_W-1:0]       offset;
    } cache_result_t;

    logic                 line_live  [NUM_LINES];
    logic [TAG_W-1:0]     line_owner [NUM_LINES];
    logic [7:0]           line_data  [NUM_LINES][BLOCK_BYTES];

    cache_result_t        cache_results [$];

    // Apply one request to the cache copy and return the result it must give.
    function automatic cache_result_t access_cache(req_kind_t kind,
                                                   logic [ADDR_W-1:0] address,
                                                   logic [DATA_W-1:0] data,
                                                   logic last);
        cache_result_t r;
        int unsigned   slot;
        int unsigned   pos;
        r.tag    = address[ADDR_W-1 -: TAG_W];
        r.index  = address[OFFSET_W +: INDEX_W];
        r.offset = address[OFFSET_W-1:0];
        r.hit    = 1'b0;
        r.value  = '0;
        slot     = r.index % NUM_LINES;
        if (kind == KIND_FILL)
        begin
            line_owner[slot] = r.tag;
            line_live[slot]  = 1'b0;
            for (int i = 0; i < BEAT_BYTES; i++)
            begin
                pos = {r.offset[OFFSET_W-1:BEAT_SHIFT], {BEAT_SHIFT{1'b0}}} + i;
                if (pos < BLOCK_BYTES)
                    line_data[slot][pos] = data[i*8 +: 8];
            end
            if (last)
                line_live[slot] = 1'b1;
        end
        else if (line_live[slot] && line_owner[slot] == r.tag)
        begin
            r.hit = 1'b1;
            for (int i = 0; i < VALUE_BYTES; i++)
            begin
                pos = r.offset + i;
                if (pos < BLOCK_BYTES)
                    r.value[i*8 +: 8] = line_data[slot][pos];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cache_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LINES; i++)
                line_live[i] = 1'b0;
            cache_results.delete();
            pending <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (cache_results.size() == 0)
                    report_mismatch("result with nothing outstanding", '0, rsp.tag_field);
                else
                begin
                    want = cache_results.pop_front();
                    if (rsp.hit !== want.hit)
                        report_mismatch("hit", want.hit, rsp.hit);
                    if (rsp.read_value !== want.value)
                        report_mismatch("read_value", want.value, rsp.read_value);
                    if (rsp.tag_field !== want.tag)
                        report_mismatch("tag_field", want.tag, rsp.tag_field);
                    if (rsp.line_index !== want.index)
                        report_mismatch("line_index", want.index, rsp.line_index);
                    if (rsp.byte_offset !== want.offset)
                        report_mismatch("byte_offset", want.offset, rsp.byte_offset);
                end
            end
            if (req.valid && req.ready)
                cache_results.push_back(access_cache(req_kind_t'(req.kind), req.address,
                                                     req.fill_data, req.fill_last));
            pending <= cache_results.size();
        end
    end

endmodule

// File: dv/testbench.sv
// ============================================================================
// testbench
// Stimulus and verdict for the direct-mapped cache lookup. Drives fill beats
// and lookups through the request channel with bursty pacing, stalls the
// result channel, and leaves prediction and comparison to the checker.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    import dmc_pkg::*;
    import dmc_tb_pkg::*;

    localparam int TARGET_REQUESTS = 1500;
    localparam int SETTLE_CYCLES   = 8;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_t;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned errors;
    int unsigned pending;

    dmc_req_if req ();
    dmc_rsp_if rsp ();

    direct_mapped_cache_lookup uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    dmc_result_checker result_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .errors  (errors),
        .pending (pending)
    );

    // Light copy of what the cache holds, kept only to steer lookups away
    // from hits on bytes that no fill has written yet.
    logic                   shadow_valid   [NUM_LINES];
    logic [TAG_W-1:0]       shadow_tag     [NUM_LINES];
    logic [BLOCK_BYTES-1:0] shadow_written [NUM_LINES];

    // A few tags reused across sessions so that lines get evicted and
    // re-owned; the extremes sit in the pool.
    logic [TAG_W-1:0] tag_pool [4];

    int unsigned sent;
    int unsigned burst_left;
    bit          drained_midway;

    int unsigned stall_left  = 0;
    int unsigned stall_phase = 0;
    stall_mode_t stall_mode  = STALL_NONE;

    always #6 clk = ~clk;

    // Give up after a generous fixed time.
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Result side: switch at random between stall patterns, including
    // stretches where ready never drops.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(40, 200);
        end
        else
            stall_left--;
        stall_phase++;
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            case (stall_mode)
                STALL_NONE:     rsp.ready <= 1'b1;
                STALL_RANDOM:   rsp.ready <= ($urandom_range(0, 3) != 0);
                STALL_PERIODIC: rsp.ready <= (stall_phase % 3 != 0);
                default:        rsp.ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        if ($urandom_range(0, 9) < 6)
            return tag_pool[$urandom_range(0, 3)];
        return TAG_W'(rand64());
    endfunction

    // Present one request and hold it until the cache takes it. Called and
    // returns at a falling edge. Open a gap before a new burst now and then.
    task automatic send_request(input req_kind_t kind, input logic [ADDR_W-1:0] address,
                                input logic [DATA_W-1:0] data, input logic last);
        int unsigned slot;
        int unsigned pos;
        int unsigned gap;
        bit          unsafe;
        slot   = address[OFFSET_W +: INDEX_W] % NUM_LINES;
        unsafe = 1'b0;
        if (kind == KIND_LOOKUP && shadow_valid[slot]
            && shadow_tag[slot] == address[ADDR_W-1 -: TAG_W])
        begin
            for (int i = 0; i < VALUE_BYTES; i++)
            begin
                pos = address[OFFSET_W-1:0] + i;
                if (pos < BLOCK_BYTES && !shadow_written[slot][pos])
                    unsafe = 1'b1;
            end
            // Turn a hit on unwritten bytes into a miss by bending the tag.
            if (unsafe)
                address[OFFSET_W + INDEX_W] = ~address[OFFSET_W + INDEX_W];
        end
        else if (kind == KIND_FILL)
        begin
            shadow_tag[slot]   = address[ADDR_W-1 -: TAG_W];
            shadow_valid[slot] = last;
            for (int i = 0; i < BEAT_BYTES; i++)
            begin
                pos = {address[OFFSET_W-1:BEAT_SHIFT], {BEAT_SHIFT{1'b0}}} + i;
                if (pos < BLOCK_BYTES)
                    shadow_written[slot][pos] = 1'b1;
            end
        end

        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end

        req.valid     <= 1'b1;
        req.kind      <= kind;
        req.address   <= address;
        req.fill_data <= data;
        req.fill_last <= last;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        sent++;
    endtask

    // Hold off the request side until every outstanding result is back.
    task automatic drain_results();
        req.valid <= 1'b0;
        burst_left = 0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    // Well-formed traffic: fill a window of one line beat by beat, then look
    // it up, mostly inside the window with the owning tag.
    task automatic run_line_session();
        logic [INDEX_W-1:0]  index;
        logic [INDEX_W-1:0]  probe_index;
        logic [TAG_W-1:0]    tag;
        logic [TAG_W-1:0]    probe_tag;
        logic [OFFSET_W-1:0] offset;
        int unsigned         beats;
        int unsigned         first;
        int unsigned         lookups;
        index = ($urandom_range(0, 1) == 0) ? INDEX_W'($urandom_range(0, 7))
                                            : INDEX_W'($urandom);
        tag   = pick_tag();
        beats = ($urandom_range(0, 9) == 0) ? WORDS_PER_LINE : $urandom_range(1, 6);
        first = $urandom_range(0, WORDS_PER_LINE - beats);
        for (int b = 0; b < beats; b++)
        begin
            // Low offset bits are noise on a fill beat; the block aligns them.
            offset = OFFSET_W'((first + b) * BEAT_BYTES + $urandom_range(0, BEAT_BYTES - 1));
            send_request(KIND_FILL, {tag, index, offset}, rand64(),
                         (b == beats - 1) && ($urandom_range(0, 9) != 0));
            // Break into the fill now and then with a lookup on the open line.
            if ($urandom_range(0, 11) == 0)
                send_request(KIND_LOOKUP, {tag, index, OFFSET_W'($urandom)}, rand64(),
                             1'($urandom));
        end
        lookups = $urandom_range(3, 10);
        for (int k = 0; k < lookups; k++)
        begin
            if ($urandom_range(0, 9) < 7)
                offset = OFFSET_W'(first * BEAT_BYTES
                                   + $urandom_range(0, beats * BEAT_BYTES - 1));
            else
                offset = OFFSET_W'($urandom);
            probe_tag   = ($urandom_range(0, 9) < 8) ? tag : pick_tag();
            probe_index = ($urandom_range(0, 9) == 0) ? INDEX_W'($urandom) : index;
            send_request(KIND_LOOKUP, {probe_tag, probe_index, offset}, rand64(),
                         1'($urandom));
        end
    endtask

    // Noise: anything the fields allow, kinds mixed.
    task automatic send_noise();
        int unsigned n;
        n = $urandom_range(1, 5);
        repeat (n)
            send_request(req_kind_t'($urandom_range(0, 1)), rand64(), rand64(), 1'($urandom));
    endtask

    initial
    begin
        rst_n          = 1'b0;
        req.valid     <= 1'b0;
        req.kind      <= KIND_LOOKUP;
        req.address   <= '0;
        req.fill_data <= '0;
        req.fill_last <= 1'b0;
        sent           = 0;
        burst_left     = 0;
        drained_midway = 1'b0;
        tag_pool[0]    = '0;
        tag_pool[1]    = '1;
        tag_pool[2]    = TAG_W'(rand64());
        tag_pool[3]    = TAG_W'(rand64());
        for (int i = 0; i < NUM_LINES; i++)
        begin
            shadow_valid[i]   = 1'b0;
            shadow_tag[i]     = '0;
            shadow_written[i] = '0;
        end

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Lookups on a cold cache miss, at both ends of the address range.
        send_request(KIND_LOOKUP, '0, '0, 1'b0);
        send_request(KIND_LOOKUP, '1, '1, 1'b1);
        // Top line, top tag: a beat without last leaves the line invalid.
        send_request(KIND_FILL, {{TAG_W{1'b1}}, 8'hff, 8'hfb}, '1, 1'b0);
        send_request(KIND_LOOKUP, {{TAG_W{1'b1}}, 8'hff, 8'hf8}, '0, 1'b0);
        send_request(KIND_FILL, {{TAG_W{1'b1}}, 8'hff, 8'hf0}, 64'h8070_6050_4030_2010, 1'b1);
        // Hits: aligned, across two beats, and running past the block end.
        send_request(KIND_LOOKUP, {{TAG_W{1'b1}}, 8'hff, 8'hf0}, '0, 1'b0);
        send_request(KIND_LOOKUP, {{TAG_W{1'b1}}, 8'hff, 8'hf5}, '0, 1'b0);
        send_request(KIND_LOOKUP, {{TAG_W{1'b1}}, 8'hff, 8'hfd}, '0, 1'b0);
        send_request(KIND_LOOKUP, {{TAG_W{1'b1}}, 8'hff, 8'hff}, '0, 1'b0);
        // Tag mismatch on a valid line.
        send_request(KIND_LOOKUP, {{{TAG_W-1{1'b1}}, 1'b0}, 8'hff, 8'hf0}, '0, 1'b0);
        // Line zero, tag zero: zero data, then all-ones data for negative words.
        send_request(KIND_FILL, '0, '0, 1'b1);
        send_request(KIND_LOOKUP, '0, '0, 1'b0);
        send_request(KIND_FILL, {{TAG_W{1'b0}}, 8'h00, 8'h08}, '1, 1'b1);
        send_request(KIND_LOOKUP, {{TAG_W{1'b0}}, 8'h00, 8'h06}, '0, 1'b0);
        send_request(KIND_LOOKUP, {{TAG_W{1'b0}}, 8'h00, 8'h0c}, '0, 1'b0);
        // A foreign beat without last takes the line and invalidates it.
        send_request(KIND_FILL, {tag_pool[2], 8'h00, 8'h10}, rand64(), 1'b0);
        send_request(KIND_LOOKUP, '0, '0, 1'b0);
        send_request(KIND_LOOKUP, {tag_pool[2], 8'h00, 8'h10}, '0, 1'b0);

        drain_results();

        while (sent < TARGET_REQUESTS)
        begin
            if (!drained_midway && sent >= TARGET_REQUESTS / 2)
            begin
                drain_results();
                drained_midway = 1'b1;
            end
            if ($urandom_range(0, 4) == 0)
                send_noise();
            else
                run_line_session();
        end

        // Drop valid, wait out the backlog, then give stray results a chance.
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
